// ===== rtl/grid_shape_painter_assert.svh =====
// assertion macros for the grid shape painter, sampled on clk and held off in reset
`ifndef GRID_SHAPE_PAINTER_ASSERT_SVH
`define GRID_SHAPE_PAINTER_ASSERT_SVH

// condition holds in the same cycle
`define GSP_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("grid shape painter check failed");

// condition holds in the next cycle
`define GSP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("grid shape painter check failed");

`endif

// ===== rtl/gsp_pkg.sv =====
package gsp_pkg;

    typedef logic signed [127:0] wide_t;
    typedef logic signed [63:0]  op_t;
    typedef logic [4:0]          cell_t;

    localparam int BIT_ACTIVE  = 0;
    localparam int BIT_SURFACE = 1;
    localparam int BIT_ESO     = 2;
    localparam int BIT_LOAD    = 3;
    localparam int BIT_SUPPORT = 4;

    localparam logic [12:0] COUNT_MAX = 13'h1FFF;

    localparam logic [1:0] REG_PITCH = 2'd0;
    localparam logic [1:0] REG_COLS  = 2'd1;
    localparam logic [1:0] REG_ROWS  = 2'd2;

    typedef enum logic [3:0] {
        MODE_DRAW_CIRCLE = 4'd0,
        MODE_CUT_CIRCLE  = 4'd1,
        MODE_RING        = 4'd2,
        MODE_DRAW_RECT   = 4'd3,
        MODE_CUT_RECT    = 4'd4,
        MODE_PRISM       = 4'd5,
        MODE_ESO         = 4'd6,
        MODE_LOAD        = 4'd7,
        MODE_SUPPORT     = 4'd8
    } mode_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_INIT,
        ST_READ,
        ST_WRITE,
        ST_DONE
    } state_t;

    typedef enum logic [4:0] {
        STEP_P2,
        STEP_DX0SQ,
        STEP_DY0SQ,
        STEP_EX0,
        STEP_EY0,
        STEP_T0,
        STEP_T1,
        STEP_T2,
        STEP_T3,
        STEP_T4,
        STEP_T5,
        STEP_T6,
        STEP_A,
        STEP_B,
        STEP_LX_C,
        STEP_LX_S,
        STEP_LY_C,
        STEP_LY_S,
        STEP_TA,
        STEP_TB,
        STEP_ET,
        STEP_SA,
        STEP_SB,
        STEP_LW,
        STEP_HW
    } step_t;

endpackage

// ===== rtl/grid_shape_painter.sv =====
// grid shape painter: paints one shape per request into a grid of cell flags
// (active, surface, eso, load, support) and returns the active and eso counts.
// channels: request in (in_valid/in_ready with mode, centre, sizes, taper,
// rotation and flag value), result out (out_valid/out_ready with the two
// counts), and an apb port for pitch, columns in use and rows in use.
// after reset the block sweeps all GRID_COLUMNS*GRID_ROWS cells of the store
// (4096 by default) to zero, one cell a cycle, and in_ready stays low.
// per request: a setup phase of 25 products on one shared shift-add
// multiplier, which steps through the bits of the first operand and stops
// once none are left; then for each cell in use a read, then a modify and
// write on the single store port.
// in_ready is high only while idle; a finished result moves into the output
// register once it is free and the block goes back to idle. a stalled
// receiver keeps the following result waiting at the end of its sweep, with
// in_ready low, until the output register frees.
`include "grid_shape_painter_assert.svh"

module grid_shape_painter #(
    parameter int GRID_COLUMNS = 64,
    parameter int GRID_ROWS    = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [3:0]         mode,
    input  logic signed [31:0] center_x,
    input  logic signed [31:0] center_y,
    input  logic [30:0]        size_a,
    input  logic [30:0]        size_b,
    input  logic signed [31:0] taper,
    input  logic signed [17:0] cos_rot,
    input  logic signed [17:0] sin_rot,
    input  logic               flag_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [12:0]        active_count,
    output logic [12:0]        eso_count
);
    import gsp_pkg::*;

    localparam int DEPTH   = GRID_COLUMNS * GRID_ROWS;
    localparam int ADDR_W  = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam int COL_W   = GRID_COLUMNS > 1 ? $clog2(GRID_COLUMNS) : 1;
    localparam int ROW_W   = GRID_ROWS > 1 ? $clog2(GRID_ROWS) : 1;
    localparam int DIM_MAX = GRID_COLUMNS > GRID_ROWS ? GRID_COLUMNS : GRID_ROWS;
    localparam int LIM_W   = $clog2(DIM_MAX + 1) > 7 ? $clog2(DIM_MAX + 1) : 7;

    // configuration
    logic [30:0] pitch_reg;
    logic [6:0]  cols_cfg_reg, rows_cfg_reg;
    logic        cfg_write;

    // control
    state_t state_reg, state_next;
    step_t  step_reg;
    logic   mul_busy_reg;
    logic   mul_start, mul_done;
    wide_t  mul_product;
    op_t    mul_a, mul_b;
    logic   in_accept;
    logic   out_load;

    // request
    logic [3:0]         mode_reg;
    logic signed [31:0] cx_reg, cy_reg, tp_reg;
    logic [30:0]        sa_reg, sb_reg;
    logic signed [17:0] cr_reg, sr_reg;
    logic               flag_reg;

    // derived lengths, doubled units
    logic signed [34:0] p_s, p2_s, sa2, sb2, dx0, dy0;
    logic signed [34:0] thr [7];
    op_t                ex_b, ey_b, wlim, hlim;

    // per request constants
    wide_t tsq_reg [7];
    logic [6:0] tneg_reg, tpos_reg;
    wide_t k8_reg, dx0sq_reg, ex0_reg, ta_reg, tb_reg, saa_reg, sab_reg, hw_reg, hwn_reg;
    op_t   a_reg, b_reg, lx00_reg, ly00_reg;

    // walking values
    wide_t d2_reg, ex_reg, dy2_reg, ey_reg, et_reg, etr_reg, lw_reg, lwr_reg;
    op_t   lx_reg, ly_reg, lxr_reg, lyr_reg;

    // sweep
    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [ADDR_W-1:0] clr_addr_reg, cell_addr, mem_addr;
    logic [LIM_W-1:0]  cols_eff, rows_eff;
    logic              last_col, last_row, last_clear;
    logic              hit, surf, hit_reg, surf_reg;
    logic [6:0]        gt_t, lt_t;
    logic              ring_in, in_x, in_y, prism_in;
    cell_t             mem [DEPTH];
    cell_t             rdata_reg, new_cell;
    logic              mem_we;
    logic [12:0]       act_cnt_reg, eso_cnt_reg;

    // result
    logic        out_valid_reg;
    logic [12:0] active_count_reg, eso_count_reg;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pitch_reg    <= 31'd65536;
            cols_cfg_reg <= 7'd64;
            rows_cfg_reg <= 7'd64;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_PITCH: pitch_reg    <= pwdata[30:0];
                REG_COLS:  cols_cfg_reg <= pwdata[6:0];
                REG_ROWS:  rows_cfg_reg <= pwdata[6:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_PITCH: prdata = {1'b0, pitch_reg};
            REG_COLS:  prdata = {25'b0, cols_cfg_reg};
            REG_ROWS:  prdata = {25'b0, rows_cfg_reg};
            default:   prdata = 32'd0;
        endcase
    end

    assign cols_eff = (LIM_W'(cols_cfg_reg) > LIM_W'(GRID_COLUMNS)) ?
                      LIM_W'(GRID_COLUMNS) : LIM_W'(cols_cfg_reg);
    assign rows_eff = (LIM_W'(rows_cfg_reg) > LIM_W'(GRID_ROWS)) ?
                      LIM_W'(GRID_ROWS) : LIM_W'(rows_cfg_reg);

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_accept = in_valid && in_ready;

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            mode_reg <= mode;
            cx_reg   <= center_x;
            cy_reg   <= center_y;
            sa_reg   <= size_a;
            sb_reg   <= size_b;
            tp_reg   <= taper;
            cr_reg   <= cos_rot;
            sr_reg   <= sin_rot;
            flag_reg <= flag_value;
        end
    end

    always_comb
    begin
        p_s    = $signed({4'b0, pitch_reg});
        p2_s   = $signed({3'b0, pitch_reg, 1'b0});
        sa2    = $signed({3'b0, sa_reg, 1'b0});
        sb2    = $signed({3'b0, sb_reg, 1'b0});
        dx0    = p_s - $signed({{2{cx_reg[31]}}, cx_reg, 1'b0});
        dy0    = p_s - $signed({{2{cy_reg[31]}}, cy_reg, 1'b0});
        thr[0] = sa2;
        thr[1] = sb2 + p_s;
        thr[2] = sa2 - p_s;
        thr[3] = sa2 - p2_s;
        thr[4] = sa2 + p2_s;
        thr[5] = sb2 - p2_s;
        thr[6] = sb2 + p2_s;
        ex_b   = (op_t'(dx0) <<< 1) + op_t'(p2_s);
        ey_b   = (op_t'(dy0) <<< 1) + op_t'(p2_s);
        wlim   = $signed({17'b0, sa_reg, 16'b0});
        hlim   = $signed({17'b0, sb_reg, 16'b0});
    end

    // operand selection for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (step_reg)
            STEP_P2:    begin mul_a = op_t'(p_s);    mul_b = op_t'(p_s);    end
            STEP_DX0SQ: begin mul_a = op_t'(dx0);    mul_b = op_t'(dx0);    end
            STEP_DY0SQ: begin mul_a = op_t'(dy0);    mul_b = op_t'(dy0);    end
            STEP_EX0:   begin mul_a = op_t'(p2_s);   mul_b = ex_b;          end
            STEP_EY0:   begin mul_a = op_t'(p2_s);   mul_b = ey_b;          end
            STEP_T0:    begin mul_a = op_t'(thr[0]); mul_b = op_t'(thr[0]); end
            STEP_T1:    begin mul_a = op_t'(thr[1]); mul_b = op_t'(thr[1]); end
            STEP_T2:    begin mul_a = op_t'(thr[2]); mul_b = op_t'(thr[2]); end
            STEP_T3:    begin mul_a = op_t'(thr[3]); mul_b = op_t'(thr[3]); end
            STEP_T4:    begin mul_a = op_t'(thr[4]); mul_b = op_t'(thr[4]); end
            STEP_T5:    begin mul_a = op_t'(thr[5]); mul_b = op_t'(thr[5]); end
            STEP_T6:    begin mul_a = op_t'(thr[6]); mul_b = op_t'(thr[6]); end
            STEP_A:     begin mul_a = op_t'(cr_reg); mul_b = op_t'(p2_s);   end
            STEP_B:     begin mul_a = op_t'(sr_reg); mul_b = op_t'(p2_s);   end
            STEP_LX_C:  begin mul_a = op_t'(cr_reg); mul_b = op_t'(dx0);    end
            STEP_LX_S:  begin mul_a = op_t'(sr_reg); mul_b = op_t'(dy0);    end
            STEP_LY_C:  begin mul_a = op_t'(cr_reg); mul_b = op_t'(dy0);    end
            STEP_LY_S:  begin mul_a = op_t'(sr_reg); mul_b = op_t'(dx0);    end
            STEP_TA:    begin mul_a = op_t'(tp_reg); mul_b = a_reg;         end
            STEP_TB:    begin mul_a = op_t'(tp_reg); mul_b = b_reg;         end
            STEP_ET:    begin mul_a = op_t'(tp_reg); mul_b = lx00_reg;      end
            STEP_SA:    begin mul_a = $signed({33'b0, sa_reg}); mul_b = a_reg;    end
            STEP_SB:    begin mul_a = $signed({33'b0, sa_reg}); mul_b = b_reg;    end
            STEP_LW:    begin mul_a = $signed({33'b0, sa_reg}); mul_b = ly00_reg; end
            STEP_HW:    begin mul_a = hlim; mul_b = $signed({33'b0, sa_reg});      end
            default:    ;
        endcase
    end

    assign mul_start = (state_reg == ST_SETUP) && !mul_busy_reg;

    gsp_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_product)
    );

    // cell tests on the walking values
    always_comb
    begin
        for (int j = 0; j < 7; j++)
        begin
            gt_t[j] = tneg_reg[j] || (d2_reg > tsq_reg[j]);
            lt_t[j] = tpos_reg[j] && (d2_reg < tsq_reg[j]);
        end
        ring_in  = !lt_t[1] && !gt_t[2];
        surf     = (gt_t[3] && lt_t[4]) || (gt_t[5] && lt_t[6]);
        in_x     = !((lx_reg < -wlim) || (lx_reg > wlim));
        in_y     = !((ly_reg < -hlim) || (ly_reg > hlim));
        prism_in = !((lw_reg - et_reg) < hwn_reg) && !((lw_reg + et_reg) > hw_reg);
        unique case (mode_reg)
            MODE_DRAW_CIRCLE, MODE_CUT_CIRCLE: hit = !(d2_reg > tsq_reg[0]);
            MODE_RING:                         hit = ring_in;
            MODE_PRISM:                        hit = in_x && ((sa_reg != 31'd0) ? prism_in : in_y);
            MODE_DRAW_RECT, MODE_CUT_RECT,
            MODE_ESO, MODE_LOAD, MODE_SUPPORT: hit = in_x && in_y;
            default:                           hit = 1'b0;
        endcase
    end

    // new flags from the old ones
    always_comb
    begin
        new_cell = rdata_reg;
        if (hit_reg)
        begin
            unique case (mode_reg)
                MODE_DRAW_CIRCLE, MODE_DRAW_RECT, MODE_PRISM: new_cell[BIT_ACTIVE] = 1'b1;
                MODE_CUT_CIRCLE, MODE_CUT_RECT:               new_cell[BIT_ACTIVE] = 1'b0;
                MODE_RING:
                begin
                    // an active cell keeps its surface mark where the ring edge lands
                    new_cell[BIT_SURFACE] = (surf_reg && rdata_reg[BIT_ACTIVE]) ?
                                            rdata_reg[BIT_SURFACE] : surf_reg;
                    new_cell[BIT_ACTIVE]  = 1'b1;
                end
                MODE_ESO:     new_cell[BIT_ESO]     = flag_reg;
                MODE_LOAD:    new_cell[BIT_LOAD]    = flag_reg;
                MODE_SUPPORT: new_cell[BIT_SUPPORT] = flag_reg;
                default:      ;
            endcase
        end
    end

    assign last_col   = (LIM_W'(LIM_W'(col_reg) + LIM_W'(1)) == cols_eff);
    assign last_row   = (LIM_W'(LIM_W'(row_reg) + LIM_W'(1)) == rows_eff);
    assign last_clear = (clr_addr_reg == ADDR_W'(DEPTH - 1));
    assign cell_addr  = ADDR_W'(row_reg * GRID_COLUMNS + col_reg);
    assign mem_addr   = (state_reg == ST_CLEAR) ? clr_addr_reg : cell_addr;
    assign mem_we     = (state_reg == ST_CLEAR) || (state_reg == ST_WRITE);
    assign out_load   = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= (state_reg == ST_CLEAR) ? cell_t'(0) : new_cell;
        end
        if (state_reg == ST_READ)
        begin
            rdata_reg <= mem[mem_addr];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (last_clear) state_next = ST_IDLE;
            ST_IDLE:  if (in_accept) state_next = ST_SETUP;
            ST_SETUP: if (mul_done && step_reg == STEP_HW) state_next = ST_INIT;
            ST_INIT:
            begin
                if (cols_eff == '0 || rows_eff == '0)
                    state_next = ST_DONE;
                else
                    state_next = ST_READ;
            end
            ST_READ:  state_next = ST_WRITE;
            ST_WRITE: state_next = (last_col && last_row) ? ST_DONE : ST_READ;
            ST_DONE:  if (out_load) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            mul_busy_reg  <= 1'b0;
            step_reg      <= STEP_P2;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            end
            if (in_accept)
            begin
                step_reg     <= STEP_P2;
                mul_busy_reg <= 1'b0;
            end
            else if (mul_start)
            begin
                mul_busy_reg <= 1'b1;
            end
            else if (mul_done)
            begin
                mul_busy_reg <= 1'b0;
                if (step_reg != STEP_HW)
                begin
                    step_reg <= step_t'(step_reg + 5'd1);
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // product store, sweep walk and counts
    always_ff @(posedge clk)
    begin
        if (mul_done)
        begin
            unique case (step_reg)
                STEP_P2:    k8_reg      <= mul_product <<< 3;
                STEP_DX0SQ: dx0sq_reg   <= mul_product;
                STEP_DY0SQ: dy2_reg     <= mul_product;
                STEP_EX0:   ex0_reg     <= mul_product;
                STEP_EY0:   ey_reg      <= mul_product;
                STEP_T0:    tsq_reg[0]  <= mul_product;
                STEP_T1:    tsq_reg[1]  <= mul_product;
                STEP_T2:    tsq_reg[2]  <= mul_product;
                STEP_T3:    tsq_reg[3]  <= mul_product;
                STEP_T4:    tsq_reg[4]  <= mul_product;
                STEP_T5:    tsq_reg[5]  <= mul_product;
                STEP_T6:    tsq_reg[6]  <= mul_product;
                STEP_A:     a_reg       <= mul_product[63:0];
                STEP_B:     b_reg       <= mul_product[63:0];
                STEP_LX_C:  lx00_reg    <= mul_product[63:0];
                STEP_LX_S:  lx00_reg    <= lx00_reg + mul_product[63:0];
                STEP_LY_C:  ly00_reg    <= mul_product[63:0];
                STEP_LY_S:  ly00_reg    <= ly00_reg - mul_product[63:0];
                STEP_TA:    ta_reg      <= mul_product;
                STEP_TB:    tb_reg      <= mul_product;
                STEP_ET:    etr_reg     <= mul_product;
                STEP_SA:    saa_reg     <= mul_product;
                STEP_SB:    sab_reg     <= mul_product;
                STEP_LW:    lwr_reg     <= mul_product;
                STEP_HW:    hw_reg      <= mul_product;
                default:    ;
            endcase
        end

        unique case (state_reg)
            ST_INIT:
            begin
                for (int j = 0; j < 7; j++)
                begin
                    tneg_reg[j] <= thr[j] < 35'sd0;
                    tpos_reg[j] <= thr[j] > 35'sd0;
                end
                hwn_reg     <= -hw_reg;
                d2_reg      <= dx0sq_reg + dy2_reg;
                ex_reg      <= ex0_reg;
                lx_reg      <= lx00_reg;
                lxr_reg     <= lx00_reg;
                ly_reg      <= ly00_reg;
                lyr_reg     <= ly00_reg;
                et_reg      <= etr_reg;
                lw_reg      <= lwr_reg;
                col_reg     <= '0;
                row_reg     <= '0;
                act_cnt_reg <= '0;
                eso_cnt_reg <= '0;
            end
            ST_READ:
            begin
                hit_reg  <= hit;
                surf_reg <= surf;
            end
            ST_WRITE:
            begin
                if (new_cell[BIT_ACTIVE] && act_cnt_reg != COUNT_MAX)
                    act_cnt_reg <= act_cnt_reg + 13'd1;
                if (new_cell[BIT_ESO] && eso_cnt_reg != COUNT_MAX)
                    eso_cnt_reg <= eso_cnt_reg + 13'd1;
                if (!last_col)
                begin
                    col_reg <= col_reg + COL_W'(1);
                    d2_reg  <= d2_reg + ex_reg;
                    ex_reg  <= ex_reg + k8_reg;
                    lx_reg  <= lx_reg + a_reg;
                    ly_reg  <= ly_reg - b_reg;
                    et_reg  <= et_reg + ta_reg;
                    lw_reg  <= lw_reg - sab_reg;
                end
                else
                begin
                    // next row starts from the row origin values
                    col_reg <= '0;
                    row_reg <= row_reg + ROW_W'(1);
                    d2_reg  <= dx0sq_reg + dy2_reg + ey_reg;
                    dy2_reg <= dy2_reg + ey_reg;
                    ey_reg  <= ey_reg + k8_reg;
                    ex_reg  <= ex0_reg;
                    lx_reg  <= lxr_reg + b_reg;
                    lxr_reg <= lxr_reg + b_reg;
                    ly_reg  <= lyr_reg + a_reg;
                    lyr_reg <= lyr_reg + a_reg;
                    et_reg  <= etr_reg + tb_reg;
                    etr_reg <= etr_reg + tb_reg;
                    lw_reg  <= lwr_reg + saa_reg;
                    lwr_reg <= lwr_reg + saa_reg;
                end
            end
            default: ;
        endcase

        if (out_load)
        begin
            active_count_reg <= act_cnt_reg;
            eso_count_reg    <= eso_cnt_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign active_count = active_count_reg;
    assign eso_count    = eso_count_reg;

    `GSP_ASSERT_IMPLY(a_clear_blocks_input, state_reg == ST_CLEAR, !in_ready)
    `GSP_ASSERT_NEXT(a_accept_starts_setup, in_accept, state_reg == ST_SETUP)
    `GSP_ASSERT_IMPLY(a_mul_done_in_setup, mul_done, state_reg == ST_SETUP)
    `GSP_ASSERT_NEXT(a_write_then_read, state_reg == ST_WRITE,
                     state_reg == ST_READ || state_reg == ST_DONE)
    `GSP_ASSERT_IMPLY(a_load_only_when_free, out_load, !out_valid_reg || out_ready)

endmodule

// ===== rtl/gsp_mul.sv =====
module gsp_mul (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  gsp_pkg::op_t  a,
    input  gsp_pkg::op_t  b,
    output logic          done,
    output gsp_pkg::wide_t product
);
    import gsp_pkg::*;

    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    logic         neg_reg, neg_next;
    logic [63:0]  ma_reg, ma_next;
    logic [127:0] mb_reg, mb_next;
    logic [127:0] acc_reg, acc_next;
    wide_t        prod_reg, prod_next;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        ma_next   = ma_reg;
        mb_next   = mb_reg;
        acc_next  = acc_reg;
        prod_next = prod_reg;
        if (start)
        begin
            ma_next   = a[63] ? 64'(-a) : 64'(a);
            mb_next   = {64'b0, (b[63] ? 64'(-b) : 64'(b))};
            acc_next  = '0;
            neg_next  = a[63] ^ b[63];
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift-add, stops once no multiplier bits are left
            if (ma_reg == 64'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                prod_next = neg_reg ? -$signed(acc_reg) : $signed(acc_reg);
            end
            else
            begin
                if (ma_reg[0])
                begin
                    acc_next = acc_reg + mb_reg;
                end
                ma_next = ma_reg >> 1;
                mb_next = mb_reg << 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg  <= neg_next;
        ma_reg   <= ma_next;
        mb_reg   <= mb_next;
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
    end

    assign done    = done_reg;
    assign product = prod_reg;

endmodule
